// File: rtl/i2cbc_pkg.sv
`timescale 1ns / 1ps

package i2cbc_pkg;

  // Counter widths
  localparam int RETRY_CNT_W = 32;
  localparam int PHASE_TMR_W = 10;

  // Widest timing register that is compared against the phase timer
  localparam int TMR_LEN_W = 10;
  localparam int TMR_CMP_W = (PHASE_TMR_W > TMR_LEN_W) ? PHASE_TMR_W : TMR_LEN_W;

  // Retry interval register width and common compare width
  localparam int RETRY_REG_W = 32;
  localparam int RETRY_CMP_W = (RETRY_CNT_W > RETRY_REG_W) ? RETRY_CNT_W : RETRY_REG_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_CLOCKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HALF       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RELEASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SETTLE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL   = 3'd5;

  typedef logic [PHASE_TMR_W-1:0] tmr_t;
  typedef logic [RETRY_CNT_W-1:0] retry_cnt_t;

  typedef enum logic [1:0] {
    MODE_UNINIT = 2'd0,
    MODE_READY  = 2'd1,
    MODE_STUCK  = 2'd2
  } bus_mode_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_CHECK     = 4'd1,
    PH_RELEASE   = 4'd2,
    PH_SAMPLE    = 4'd3,
    PH_LOW       = 4'd4,
    PH_RISE      = 4'd5,
    PH_HIGH      = 4'd6,
    PH_STOP_SCL  = 4'd7,
    PH_STOP_SDA  = 4'd8,
    PH_STOP_RISE = 4'd9,
    PH_STOP_HOLD = 4'd10,
    PH_SDA_RISE  = 4'd11
  } phase_e;

  typedef struct packed {
    logic [4:0]             recover_clocks;
    logic [7:0]             pulse_half_ticks;
    logic [7:0]             initial_release_ticks;
    logic [9:0]             release_timeout_ticks;
    logic [9:0]             idle_settle_ticks;
    logic [RETRY_REG_W-1:0] retry_interval_ticks;
  } cfg_t;

  typedef struct packed {
    bus_mode_e  bus_mode;
    phase_e     phase;
    tmr_t       phase_timer;
    retry_cnt_t since_last_attempt;
    logic [4:0] pulses_given;
    logic       sda_seen_high;
    logic       scl_rose_for_stop;
    logic [3:0] fault_mask;
  } seq_state_t;

  typedef struct packed {
    logic command;
    logic sda_level;
    logic scl_level;
  } in_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic [1:0] bus_status;
    logic       busy_res;
    logic       answer_valid;
    logic [3:0] stuck_mask;
  } out_t;

endpackage

// File: rtl/i2cbc_cfg.sv
`timescale 1ns / 1ps

module i2cbc_cfg import i2cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RECOVER_CLOCKS:  cfg_d.recover_clocks        = cfg_wdata_i[4:0];
        CFG_PULSE_HALF:      cfg_d.pulse_half_ticks      = cfg_wdata_i[7:0];
        CFG_INITIAL_RELEASE: cfg_d.initial_release_ticks = cfg_wdata_i[7:0];
        CFG_RELEASE_TIMEOUT: cfg_d.release_timeout_ticks = cfg_wdata_i[9:0];
        CFG_IDLE_SETTLE:     cfg_d.idle_settle_ticks     = cfg_wdata_i[9:0];
        CFG_RETRY_INTERVAL:  cfg_d.retry_interval_ticks  = cfg_wdata_i[RETRY_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recover_clocks        <= 5'd18;
      cfg_q.pulse_half_ticks      <= 8'd5;
      cfg_q.initial_release_ticks <= 8'd10;
      cfg_q.release_timeout_ticks <= 10'd100;
      cfg_q.idle_settle_ticks     <= 10'd500;
      cfg_q.retry_interval_ticks  <= RETRY_REG_W'(1000000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/i2cbc_step.sv
`timescale 1ns / 1ps

module i2cbc_step import i2cbc_pkg::*; (
  input  cfg_t       cfg_i,
  input  seq_state_t state_i,
  input  in_t        tick_i,
  output seq_state_t state_o,
  output out_t       res_o
);

  localparam tmr_t       TMR_MAX   = '1;
  localparam retry_cnt_t RETRY_MAX = '1;

  // Hold phase has served its length
  function automatic logic hold_end(tmr_t t, logic [TMR_LEN_W-1:0] len);
    hold_end = (TMR_CMP_W'(t) >= TMR_CMP_W'(len)) || (t == TMR_MAX);
  endfunction

  // Rise wait expired, evaluated on the already advanced timer
  function automatic logic wait_end(tmr_t t1, logic [TMR_LEN_W-1:0] len);
    wait_end = (TMR_CMP_W'(t1) >= TMR_CMP_W'(len)) || (t1 == TMR_MAX);
  endfunction

  seq_state_t nx;
  logic       answered;
  retry_cnt_t since_inc;
  tmr_t       tmr_inc;
  tmr_t       poll_t1;
  logic       retry_due;
  logic       sda_hi;
  logic       fin_sda;
  logic       do_finish;
  logic [3:0] fin_mask;

  // Saturating counters and shared compares
  always_comb begin
    since_inc = (state_i.since_last_attempt == RETRY_MAX) ? state_i.since_last_attempt
                                                          : state_i.since_last_attempt + 1'b1;
    tmr_inc   = (state_i.phase_timer == TMR_MAX) ? state_i.phase_timer
                                                 : state_i.phase_timer + 1'b1;
    // a fresh idle check starts from a cleared timer
    poll_t1   = (state_i.phase == PH_IDLE) ? tmr_t'(1) : tmr_inc;
    retry_due = RETRY_CMP_W'(since_inc) >= RETRY_CMP_W'(cfg_i.retry_interval_ticks);
    sda_hi    = tick_i.sda_level;
  end

  // Phase sequencer: one tick per pass
  always_comb begin
    nx = state_i;
    nx.since_last_attempt = since_inc;
    answered  = 1'b0;
    do_finish = 1'b0;
    fin_sda   = 1'b0;
    case (state_i.phase)
      PH_IDLE, PH_CHECK: begin
        if (state_i.phase == PH_CHECK || tick_i.command) begin
          if (state_i.phase == PH_IDLE && state_i.bus_mode == MODE_UNINIT) begin
            nx.since_last_attempt = '0;
            nx.pulses_given       = '0;
            nx.sda_seen_high      = 1'b0;
            nx.scl_rose_for_stop  = 1'b0;
            nx.phase              = PH_RELEASE;
            nx.phase_timer        = tmr_t'(1);
          end else if (state_i.phase == PH_IDLE && state_i.bus_mode != MODE_READY) begin
            // stuck: retry only after the interval
            if (!retry_due) begin
              answered = 1'b1;
              nx.phase = PH_IDLE;
              nx.phase_timer = '0;
            end else begin
              nx.since_last_attempt = '0;
              nx.pulses_given       = '0;
              nx.sda_seen_high      = 1'b0;
              nx.scl_rose_for_stop  = 1'b0;
              nx.phase              = PH_RELEASE;
              nx.phase_timer        = tmr_t'(1);
            end
          end else if (tick_i.sda_level && tick_i.scl_level) begin
            // bus is idle
            answered = 1'b1;
            nx.phase = PH_IDLE;
            nx.phase_timer = '0;
          end else if (wait_end(poll_t1, cfg_i.idle_settle_ticks)) begin
            nx.bus_mode = MODE_STUCK;
            if (!retry_due) begin
              answered = 1'b1;
              nx.phase = PH_IDLE;
              nx.phase_timer = '0;
            end else begin
              nx.since_last_attempt = '0;
              nx.pulses_given       = '0;
              nx.sda_seen_high      = 1'b0;
              nx.scl_rose_for_stop  = 1'b0;
              nx.phase              = PH_RELEASE;
              nx.phase_timer        = tmr_t'(1);
            end
          end else begin
            nx.phase = PH_CHECK;
            nx.phase_timer = poll_t1;
          end
        end
      end
      PH_RELEASE: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.initial_release_ticks))) begin
          nx.phase = PH_SAMPLE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_SAMPLE: begin
        nx.phase_timer = tmr_t'(1);
        if (state_i.pulses_given >= cfg_i.recover_clocks) begin
          nx.phase = PH_STOP_SCL;
        end else if (sda_hi) begin
          nx.sda_seen_high = 1'b1;
          nx.phase = PH_STOP_SCL;
        end else begin
          nx.phase = PH_LOW;
        end
      end
      PH_LOW: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.pulse_half_ticks))) begin
          nx.phase = PH_RISE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_RISE: begin
        if (tick_i.scl_level) begin
          nx.phase = PH_HIGH;
          nx.phase_timer = tmr_t'(1);
        end else if (wait_end(tmr_inc, cfg_i.release_timeout_ticks)) begin
          // SCL held low by someone else: stop clocking
          nx.phase = PH_STOP_SCL;
          nx.phase_timer = tmr_t'(1);
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_HIGH: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.pulse_half_ticks))) begin
          nx.pulses_given = state_i.pulses_given + 1'b1;
          nx.phase = PH_SAMPLE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_STOP_SCL: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.pulse_half_ticks))) begin
          nx.phase = PH_STOP_SDA;
          nx.phase_timer = tmr_t'(1);
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_STOP_SDA: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.pulse_half_ticks))) begin
          nx.phase = PH_STOP_RISE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_STOP_RISE: begin
        if (tick_i.scl_level) begin
          nx.scl_rose_for_stop = 1'b1;
          nx.phase = PH_STOP_HOLD;
          nx.phase_timer = tmr_t'(1);
        end else if (wait_end(tmr_inc, cfg_i.release_timeout_ticks)) begin
          nx.scl_rose_for_stop = 1'b0;
          nx.phase = PH_SDA_RISE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_STOP_HOLD: begin
        if (hold_end(state_i.phase_timer, TMR_LEN_W'(cfg_i.pulse_half_ticks))) begin
          nx.phase = PH_SDA_RISE;
          nx.phase_timer = '0;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      PH_SDA_RISE: begin
        if (sda_hi) begin
          do_finish = 1'b1;
          fin_sda   = 1'b1;
        end else if (wait_end(tmr_inc, cfg_i.release_timeout_ticks)) begin
          do_finish = 1'b1;
        end else begin
          nx.phase_timer = tmr_inc;
        end
      end
      default: begin
        nx.phase = PH_IDLE;
        nx.phase_timer = '0;
      end
    endcase

    // Wrap-up: record the fault mask and the new bus state
    fin_mask = {~fin_sda & ~state_i.sda_seen_high, ~state_i.scl_rose_for_stop,
                ~tick_i.scl_level, ~fin_sda};
    if (do_finish) begin
      answered = 1'b1;
      nx.fault_mask = fin_mask;
      nx.bus_mode = (fin_sda && tick_i.scl_level && state_i.scl_rose_for_stop)
                    ? MODE_READY : MODE_STUCK;
      nx.phase = PH_IDLE;
      nx.phase_timer = '0;
    end
  end

  // Line drives and status follow the phase after the tick
  always_comb begin
    res_o.scl_drive_low = (nx.phase == PH_LOW) || (nx.phase == PH_STOP_SCL) ||
                          (nx.phase == PH_STOP_SDA);
    res_o.sda_drive_low = (nx.phase == PH_STOP_SDA) || (nx.phase == PH_STOP_RISE) ||
                          (nx.phase == PH_STOP_HOLD);
    res_o.bus_status    = nx.bus_mode;
    res_o.busy_res      = (nx.phase != PH_IDLE);
    res_o.answer_valid  = answered;
    res_o.stuck_mask    = nx.fault_mask;
  end

  assign state_o = nx;

endmodule

// File: rtl/i2c_bus_clear_sequencer.sv
`timescale 1ns / 1ps
// The result of an input transfer is registered into the output register and is held there from the next cycle.
// Throughput: one tick per cycle; the next tick is taken while a result waits,
// as long as the output register is empty or is drained in the same cycle.
// Reset (rst_ni low, asynchronous): bus uninitialized, phase idle, all counters
// and the stuck mask cleared, registers at their default values, no result held.
module i2c_bus_clear_sequencer import i2cbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t       cfg;
  seq_state_t state_q, state_d;
  out_t       res_d, res_q;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  i2cbc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  i2cbc_step u_step (
    .cfg_i  (cfg),
    .state_i(state_q),
    .tick_i (in_data_i),
    .state_o(state_d),
    .res_o  (res_d)
  );

  // Take a tick whenever the output register is free or drains this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.bus_mode           <= MODE_UNINIT;
      state_q.phase              <= PH_IDLE;
      state_q.phase_timer        <= '0;
      state_q.since_last_attempt <= '0;
      state_q.pulses_given       <= '0;
      state_q.sda_seen_high      <= 1'b0;
      state_q.scl_rose_for_stop  <= 1'b0;
      state_q.fault_mask         <= '0;
      out_valid_q                <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // A completed request always leaves the sequencer idle
  a_answer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_d.answer_valid |=> state_q.phase == PH_IDLE)
    else $error("answered request left sequencer busy");

  // State only advances on an input transfer
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state changed without an input transfer");

  // Starting a recovery clears the retry counter
  a_retry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && state_q.phase != PH_RELEASE && state_d.phase == PH_RELEASE
    |=> state_q.since_last_attempt == '0)
    else $error("retry counter not cleared at recovery start");

  // The busy flag in the result matches the stored phase
  a_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_data_o.busy_res == (state_q.phase != PH_IDLE))
    else $error("busy flag disagrees with phase");

endmodule
